// ===== src/k_group_stream_reverser_top_defines.svh =====
// assertion macros for the k-group stream reverser
`ifndef K_GROUP_STREAM_REVERSER_TOP_DEFINES_SVH
`define K_GROUP_STREAM_REVERSER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KGSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kgsr same-cycle check failed");

// next-cycle implication, checked out of reset
`define KGSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kgsr next-cycle check failed");

`endif

// ===== src/kgsr_pkg.sv =====
// shared constants, types and helpers of the k-group stream reverser
`timescale 1ns / 1ps

package kgsr_pkg;

  localparam int MAX_GROUP = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 5;
  localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LD
  } st_t;

  // clamp the configured group size into 1..MAX_GROUP
  function automatic logic [CNT_W-1:0] eff_group(input logic [CFG_W-1:0] g);
    int unsigned gi;
    gi = g;
    if (gi < 1) gi = 1;
    if (gi > MAX_GROUP) gi = MAX_GROUP;
    return CNT_W'(gi);
  endfunction

endpackage

// ===== src/kgsr_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module kgsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/k_group_stream_reverser_top.sv =====
// top level of the k-group stream reverser
`timescale 1ns / 1ps
`include "k_group_stream_reverser_top_defines.svh"

// k-group stream reverser: signed 32-bit values arrive one per input
// transaction and are written into a 16-entry group buffer ram. once the
// buffer holds group_size values (clamped to 1..16; 0 acts as 1) the whole
// group is sent out newest-first; if a transaction carrying in_stream_last
// leaves a partial group, that remainder is sent out oldest-first.
// out_burst_last marks the last result caused by an input transaction and
// out_stream_end the last result caused by the stream's final transaction.
// timing: an input transaction that causes no result leaves the block in
// idle, still ready. one that causes n results is written first, then
// each result passes through ST_RD for the ram's registered read and
// ST_LD to load the output register, which waits while it holds a result
// and out_ready is low; in_ready returns after the last result. the single
// read port of the buffer ram paces the burst. a finished result waits in
// the output register while the next input transaction is taken.
// cfg_we writes group_size; write it only while the block is idle.
module k_group_stream_reverser_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             cfg_we,
  input  logic [kgsr_pkg::CFG_W-1:0]       cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [kgsr_pkg::DATA_W-1:0] in_value,
  input  logic                             in_stream_last,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [kgsr_pkg::DATA_W-1:0] out_value,
  output logic                             out_burst_last,
  output logic                             out_stream_end
);

  // control state
  kgsr_pkg::st_t                  state_r, state_nxt;
  logic [kgsr_pkg::CFG_W-1:0]     group_size_r;
  logic [kgsr_pkg::CNT_W-1:0]     fill_r, fill_nxt;     // values held in the buffer
  logic [kgsr_pkg::CNT_W-1:0]     rem_r, rem_nxt;       // results left in this burst
  logic [kgsr_pkg::ADDR_W-1:0]    addr_r, addr_nxt;     // next buffer entry to read
  logic                           down_r, down_nxt;     // reverse order burst
  logic                           last_r, last_nxt;     // burst caused by stream end
  logic                           out_valid_r, out_valid_nxt;

  // output payload
  logic signed [kgsr_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                               out_burst_last_r, out_burst_last_nxt;
  logic                               out_stream_end_r, out_stream_end_nxt;

  // buffer ram ports
  logic                           ram_we;
  logic                           ram_re;
  logic [kgsr_pkg::DATA_W-1:0]    ram_rdata;

  logic                           in_acc;
  logic                           out_acc;
  logic                           out_free;
  logic [kgsr_pkg::CNT_W-1:0]     new_fill;
  logic [kgsr_pkg::CNT_W-1:0]     grp;

  assign in_ready = (state_r == kgsr_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign out_free = !out_valid_r || out_ready;
  assign new_fill = fill_r + kgsr_pkg::CNT_W'(1);
  assign grp      = kgsr_pkg::eff_group(group_size_r);

  // new value lands at the current fill position
  assign ram_we = in_acc;
  assign ram_re = (state_r == kgsr_pkg::ST_RD);

  kgsr_ram #(
    .WIDTH (kgsr_pkg::DATA_W),
    .DEPTH (kgsr_pkg::MAX_GROUP)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[kgsr_pkg::ADDR_W-1:0]),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kgsr_pkg::ST_IDLE;
      group_size_r <= kgsr_pkg::GROUP_SIZE_RST;
      fill_r       <= '0;
      rem_r        <= '0;
      addr_r       <= '0;
      down_r       <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      addr_r      <= addr_nxt;
      down_r      <= down_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        group_size_r <= cfg_wdata;
      end
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk) begin
    out_value_r      <= out_value_nxt;
    out_burst_last_r <= out_burst_last_nxt;
    out_stream_end_r <= out_stream_end_nxt;
  end

  always_comb begin
    state_nxt          = state_r;
    fill_nxt           = fill_r;
    rem_nxt            = rem_r;
    addr_nxt           = addr_r;
    down_nxt           = down_r;
    last_nxt           = last_r;
    out_valid_nxt      = out_valid_r && !out_acc;
    out_value_nxt      = out_value_r;
    out_burst_last_nxt = out_burst_last_r;
    out_stream_end_nxt = out_stream_end_r;

    case (state_r)
      kgsr_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_stream_last;
          if (new_fill >= grp) begin
            // full group (or size lowered mid-group): newest first
            state_nxt = kgsr_pkg::ST_RD;
            rem_nxt   = new_fill;
            addr_nxt  = fill_r[kgsr_pkg::ADDR_W-1:0];
            down_nxt  = 1'b1;
            fill_nxt  = '0;
          end else if (in_stream_last) begin
            // partial group at stream end: arrival order
            state_nxt = kgsr_pkg::ST_RD;
            rem_nxt   = new_fill;
            addr_nxt  = '0;
            down_nxt  = 1'b0;
            fill_nxt  = '0;
          end else begin
            fill_nxt = new_fill;
          end
        end
      end

      kgsr_pkg::ST_RD: begin
        // read issued this cycle, data next cycle
        state_nxt = kgsr_pkg::ST_LD;
        addr_nxt  = down_r ? (addr_r - kgsr_pkg::ADDR_W'(1))
                           : (addr_r + kgsr_pkg::ADDR_W'(1));
      end

      kgsr_pkg::ST_LD: begin
        // ram data holds until the output register frees up
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_value_nxt      = ram_rdata;
          out_burst_last_nxt = (rem_r == kgsr_pkg::CNT_W'(1));
          out_stream_end_nxt = last_r && (rem_r == kgsr_pkg::CNT_W'(1));
          rem_nxt            = rem_r - kgsr_pkg::CNT_W'(1);
          state_nxt          = (rem_r == kgsr_pkg::CNT_W'(1)) ? kgsr_pkg::ST_IDLE
                                                              : kgsr_pkg::ST_RD;
        end
      end

      default: begin
        state_nxt = kgsr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_burst_last = out_burst_last_r;
  assign out_stream_end = out_stream_end_r;

  // the buffer never holds MAX_GROUP values between transactions
  `KGSR_ASSERT_IMP(a_fill_below_max, 1'b1, fill_r < kgsr_pkg::CNT_W'(kgsr_pkg::MAX_GROUP))
  // no burst left over once back in idle
  `KGSR_ASSERT_IMP(a_idle_no_burst, state_r == kgsr_pkg::ST_IDLE, rem_r == '0)
  // a stream-end transaction always empties the buffer
  `KGSR_ASSERT_NXT(a_last_empties, in_acc && in_stream_last, fill_r == '0)

endmodule
